[src/fbti_pkg.sv]
package fbti_pkg;

   // table geometry default
   localparam int SIDE_DEFAULT = 10;
   localparam int ENTRY_W      = 16;

   // fixed-point constants
   localparam logic [ENTRY_W-1:0] UNITY    = 16'd16384;
   localparam logic [16:0]        HALF_Q16 = 17'd32768;
   localparam logic [16:0]        ONE_Q16  = 17'h10000;

   // configuration register reset values (unsigned Q8.16)
   localparam int SCALE_W = 24;
   localparam logic [SCALE_W-1:0] POS_SCALE_RESET = 24'd1310720;
   localparam logic [SCALE_W-1:0] ANG_SCALE_RESET = 24'd65536;

   // request kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // pipeline stage numbering
   localparam int STAGES   = 7;
   localparam int ST_FOLD  = 0;
   localparam int ST_SCALE = 1;
   localparam int ST_COORD = 2;
   localparam int ST_ADDR  = 3;
   localparam int ST_MEM   = 4;
   localparam int ST_PROD  = 5;
   localparam int ST_OUT   = 6;

   // unpacked request fields
   typedef struct packed {
      logic               op;
      logic [1:0]         side;
      logic signed [31:0] strip_position;
      logic signed [23:0] impact_angle;
      logic [3:0]         entry_row;
      logic [3:0]         entry_column;
      logic [15:0]        entry_value;
   } fbti_req_type;

   // per-item tag carried down the pipe
   typedef struct packed {
      logic               is_query;
      logic               unity;
      logic               wr_ok;
      logic               side0;
      logic [3:0]         row;
      logic [3:0]         col;
      logic [ENTRY_W-1:0] value;
   } fbti_tag_type;

   // stage control from the top level
   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] full;
      logic              clearing;
   } fbti_ctrl_type;

endpackage

[src/folded_bilinear_table_interp.sv]
// queries pass the fold, scale, coordinate, address, table, product, output stages to rsp_tvalid
// throughput: one request per cycle; each stage holds one item and moves when the next frees up
// the rate is set by the four table copies, one read port each, feeding one lookup a cycle
// reset (synchronous, active high) empties the pipe and loads both scale registers;
// then a sweep writes 1.0 into all 2*TABLE_SIDE*TABLE_SIDE table entries, one per cycle
// (200 entries at the default size) while req_tready is held low
module folded_bilinear_table_interp
   import fbti_pkg::*;
#(
   parameter int TABLE_SIDE = SIDE_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,

   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: strip_position[31:0], impact_angle[55:32], entry_row[59:56],
   //        entry_column[63:60], entry_value[79:64]
   input  logic [79:0]  req_tdata,
   // tuser: op[0], side[2:1]
   input  logic [2:0]   req_tuser,

   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: loss_factor[15:0]
   output logic [15:0]  rsp_tdata,

   // configuration writes
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_SIDE);
   localparam int CW    = IDX_W + 16;
   localparam int DEPTH = 2 * TABLE_SIDE * TABLE_SIDE;
   localparam int AW    = $clog2(DEPTH);

   // register indexes
   localparam logic CSR_POS_SCALE = 1'b0;
   localparam logic CSR_ANG_SCALE = 1'b1;

   // scale registers
   logic [SCALE_W-1:0] pos_scale_ff, ang_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_scale_ff <= POS_SCALE_RESET;
         ang_scale_ff <= ANG_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POS_SCALE: pos_scale_ff <= csr_wdata;
            CSR_ANG_SCALE: ang_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table clearing sweep after reset
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // stage occupancy and advance; a stage loads when empty or when its item moves on
   logic [STAGES-1:0] full_ff, full_in, load;
   logic              query_at_addr;
   logic              accept;

   always_comb begin
      load[STAGES-1] = !full_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !full_ff[i] || load[i+1];
      end
   end

   assign req_tready = load[ST_FOLD] && !clr_busy_ff;
   assign accept     = req_tvalid && req_tready;

   // table writes end at the table stage, only queries go on
   always_comb begin
      full_in = full_ff;
      for (int i = 0; i < STAGES; i++) begin
         if (load[i]) begin
            if (i == ST_FOLD) begin
               full_in[i] = accept;
            end else if (i == ST_MEM) begin
               full_in[i] = full_ff[i-1] && query_at_addr;
            end else begin
               full_in[i] = full_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   fbti_ctrl_type ctrl;
   assign ctrl.load     = load;
   assign ctrl.full     = full_ff;
   assign ctrl.clearing = clr_busy_ff;

   // request unpacking
   fbti_req_type req;
   assign req.op             = req_tuser[0];
   assign req.side           = req_tuser[2:1];
   assign req.strip_position = req_tdata[31:0];
   assign req.impact_angle   = req_tdata[55:32];
   assign req.entry_row      = req_tdata[59:56];
   assign req.entry_column   = req_tdata[63:60];
   assign req.entry_value    = req_tdata[79:64];

   // fold, scale, coordinate
   fbti_tag_type  tag3;
   logic [CW-1:0] pos_coord, ang_coord;

   fbti_front #(
      .TABLE_SIDE (TABLE_SIDE)
   ) u_front (
      .clock     (clock),
      .ctrl      (ctrl),
      .req       (req),
      .pos_scale (pos_scale_ff),
      .ang_scale (ang_scale_ff),
      .tag       (tag3),
      .pos_coord (pos_coord),
      .ang_coord (ang_coord)
   );

   // corner addresses, weights, table read and entry write
   logic               unity5;
   logic [ENTRY_W-1:0] entry [4];
   logic [32:0]        weight [4];

   fbti_lookup #(
      .TABLE_SIDE (TABLE_SIDE)
   ) u_lookup (
      .clock         (clock),
      .ctrl          (ctrl),
      .clr_addr      (clr_addr_ff),
      .tag           (tag3),
      .pos_coord     (pos_coord),
      .ang_coord     (ang_coord),
      .query_at_addr (query_at_addr),
      .unity         (unity5),
      .entry         (entry),
      .weight        (weight)
   );

   // weighted sum into the output register
   logic [ENTRY_W-1:0] loss_factor;

   fbti_blend u_blend (
      .clock       (clock),
      .ctrl        (ctrl),
      .unity       (unity5),
      .entry       (entry),
      .weight      (weight),
      .loss_factor (loss_factor)
   );

   assign rsp_tvalid = full_ff[ST_OUT];
   assign rsp_tdata  = loss_factor;

`ifndef SYNTH
   // no request gets in while the table is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock)
      clr_busy_ff |-> !req_tready)
      else $error("request accepted during table clear");

   // the sweep runs once per reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("table clear restarted without reset");

   // nothing reaches the output while the table is being cleared
   a_empty_in_clear: assert property (@(posedge clock)
      clr_busy_ff |-> (full_ff == '0))
      else $error("pipeline busy during table clear");

   // a blocked coordinate stage keeps its item
   a_hold_coord: assert property (@(posedge clock) disable iff (reset)
      full_ff[ST_COORD] && !load[ST_ADDR] |=> full_ff[ST_COORD])
      else $error("stalled item lost in coordinate stage");
`endif

endmodule

[src/fbti_table_ram.sv]
module fbti_table_ram
   import fbti_pkg::*;
#(
   parameter int DEPTH = 2 * SIDE_DEFAULT * SIDE_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] table_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fbti_front.sv]
module fbti_front
   import fbti_pkg::*;
#(
   parameter int TABLE_SIDE = SIDE_DEFAULT,
   localparam int IDX_W = $clog2(TABLE_SIDE),
   localparam int CW = IDX_W + 16
) (
   input  logic               clock,
   input  fbti_ctrl_type      ctrl,
   input  fbti_req_type       req,
   input  logic [SCALE_W-1:0] pos_scale,
   input  logic [SCALE_W-1:0] ang_scale,
   output fbti_tag_type       tag,
   output logic [CW-1:0]      pos_coord,
   output logic [CW-1:0]      ang_coord
);

   localparam logic [5:0] SIDE_L = 6'(TABLE_SIDE);
   localparam int TOP = (TABLE_SIDE - 1) * 65536;

   // bin coordinate minus one half, clamped to the table
   function automatic logic [CW-1:0] bin_coord(input logic [31:0] c);
      logic [31:0] d;
      d = c - 32'(HALF_Q16);
      if (c <= 32'(HALF_Q16)) begin
         bin_coord = '0;
      end else if (d > 32'(TOP)) begin
         bin_coord = CW'(TOP);
      end else begin
         bin_coord = CW'(d);
      end
   endfunction

   // fold stage
   logic [15:0]  frac;
   logic [23:0]  ang_bits;
   logic [16:0]  pmag_in, pmag_ff;
   logic [23:0]  amag_in, amag_ff;
   fbti_tag_type tag1_in, tag1_ff;

   assign frac     = req.strip_position[15:0];
   assign ang_bits = req.impact_angle;
   assign pmag_in  = ({1'b0, frac} <= HALF_Q16) ? {1'b0, frac} : (ONE_Q16 - {1'b0, frac});
   assign amag_in  = ang_bits[23] ? (~ang_bits + 24'd1) : ang_bits;

   always_comb begin
      tag1_in.is_query = (req.op == OP_QUERY);
      tag1_in.unity    = req.side[1];
      tag1_in.wr_ok    = (req.op == OP_WRITE) && !req.side[1]
                         && ({2'b00, req.entry_row} < SIDE_L)
                         && ({2'b00, req.entry_column} < SIDE_L);
      tag1_in.side0    = req.side[0];
      tag1_in.row      = req.entry_row;
      tag1_in.col      = req.entry_column;
      tag1_in.value    = req.entry_value;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_FOLD]) begin
         tag1_ff <= tag1_in;
         pmag_ff <= pmag_in;
         amag_ff <= amag_in;
      end
   end

   // scale stage
   logic [40:0]  pprod_in, pprod_ff;
   logic [47:0]  aprod_in, aprod_ff;
   fbti_tag_type tag2_ff;

   assign pprod_in = 41'(pmag_ff) * 41'(pos_scale);
   assign aprod_in = 48'(amag_ff) * 48'(ang_scale);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_SCALE]) begin
         tag2_ff  <= tag1_ff;
         pprod_ff <= pprod_in;
         aprod_ff <= aprod_in;
      end
   end

   // coordinate stage
   logic [CW-1:0] pc_in, pc_ff, ac_in, ac_ff;
   fbti_tag_type  tag3_ff;

   assign pc_in = bin_coord(32'(pprod_ff[40:16]));
   assign ac_in = bin_coord(aprod_ff[47:16]);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_COORD]) begin
         tag3_ff <= tag2_ff;
         pc_ff   <= pc_in;
         ac_ff   <= ac_in;
      end
   end

   assign tag       = tag3_ff;
   assign pos_coord = pc_ff;
   assign ang_coord = ac_ff;

endmodule

[src/fbti_lookup.sv]
module fbti_lookup
   import fbti_pkg::*;
#(
   parameter int TABLE_SIDE = SIDE_DEFAULT,
   localparam int IDX_W = $clog2(TABLE_SIDE),
   localparam int CW = IDX_W + 16,
   localparam int CELLS = TABLE_SIDE * TABLE_SIDE,
   localparam int DEPTH = 2 * CELLS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  fbti_ctrl_type      ctrl,
   input  logic [AW-1:0]      clr_addr,
   input  fbti_tag_type       tag,
   input  logic [CW-1:0]      pos_coord,
   input  logic [CW-1:0]      ang_coord,
   output logic               query_at_addr,
   output logic               unity,
   output logic [ENTRY_W-1:0] entry [4],
   output logic [32:0]        weight [4]
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIDE - 1);

   function automatic logic [AW-1:0] cell_addr(input logic side0, input logic [5:0] r,
                                               input logic [5:0] c);
      cell_addr = (side0 ? AW'(CELLS) : AW'(0)) + AW'(r) * AW'(TABLE_SIDE) + AW'(c);
   endfunction

   // corner indices, upper neighbor clamped at the last bin
   logic [IDX_W-1:0] ip, ia, ip1, ia1;
   logic [15:0]      up, ua;
   logic [16:0]      wp0, wp1, wa0, wa1;
   logic [33:0]      wfull [4];
   logic [AW-1:0]    raddr_in [4];
   logic [AW-1:0]    waddr_in;

   assign ip  = pos_coord[CW-1:16];
   assign ia  = ang_coord[CW-1:16];
   assign up  = pos_coord[15:0];
   assign ua  = ang_coord[15:0];
   assign ip1 = (ip == LAST) ? ip : ip + 1'b1;
   assign ia1 = (ia == LAST) ? ia : ia + 1'b1;
   assign wp1 = {1'b0, up};
   assign wa1 = {1'b0, ua};
   assign wp0 = ONE_Q16 - wp1;
   assign wa0 = ONE_Q16 - wa1;

   // corners: (ip,ia) (ip+1,ia) (ip,ia+1) (ip+1,ia+1)
   assign wfull[0] = 34'(wp0) * 34'(wa0);
   assign wfull[1] = 34'(wp1) * 34'(wa0);
   assign wfull[2] = 34'(wp0) * 34'(wa1);
   assign wfull[3] = 34'(wp1) * 34'(wa1);

   assign raddr_in[0] = cell_addr(tag.side0, 6'(ip),  6'(ia));
   assign raddr_in[1] = cell_addr(tag.side0, 6'(ip1), 6'(ia));
   assign raddr_in[2] = cell_addr(tag.side0, 6'(ip),  6'(ia1));
   assign raddr_in[3] = cell_addr(tag.side0, 6'(ip1), 6'(ia1));
   assign waddr_in    = cell_addr(tag.side0, {2'b00, tag.row}, {2'b00, tag.col});

   // address stage
   fbti_tag_type  tag4_ff;
   logic [AW-1:0] raddr_ff [4];
   logic [AW-1:0] waddr_ff;
   logic [32:0]   w4_ff [4];

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_ADDR]) begin
         tag4_ff  <= tag;
         waddr_ff <= waddr_in;
         for (int k = 0; k < 4; k++) begin
            raddr_ff[k] <= raddr_in[k];
            w4_ff[k]    <= wfull[k][32:0];
         end
      end
   end

   // table stage: writes land here so they stay in order with reads
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   assign mem_we    = ctrl.clearing
                      || (ctrl.load[ST_MEM] && ctrl.full[ST_ADDR] && tag4_ff.wr_ok);
   assign mem_waddr = ctrl.clearing ? clr_addr : waddr_ff;
   assign mem_wdata = ctrl.clearing ? UNITY : tag4_ff.value;

   for (genvar g = 0; g < 4; g++) begin : g_copy
      fbti_table_ram #(
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (mem_we),
         .wr_addr (mem_waddr),
         .wr_data (mem_wdata),
         .rd_en   (ctrl.load[ST_MEM]),
         .rd_addr (raddr_ff[g]),
         .rd_data (entry[g])
      );
   end

   logic        unity5_ff;
   logic [32:0] w5_ff [4];

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MEM]) begin
         unity5_ff <= tag4_ff.unity;
         w5_ff     <= w4_ff;
      end
   end

   assign query_at_addr = tag4_ff.is_query;
   assign unity         = unity5_ff;
   assign weight        = w5_ff;

endmodule

[src/fbti_blend.sv]
module fbti_blend
   import fbti_pkg::*;
(
   input  logic               clock,
   input  fbti_ctrl_type      ctrl,
   input  logic               unity,
   input  logic [ENTRY_W-1:0] entry [4],
   input  logic [32:0]        weight [4],
   output logic [ENTRY_W-1:0] loss_factor
);

   localparam logic [49:0] ROUND = 50'h0_8000_0000;

   // product stage
   logic [48:0] prod_in [4];
   logic [48:0] prod_ff [4];
   logic        unity6_ff;

   for (genvar g = 0; g < 4; g++) begin : g_mul
      assign prod_in[g] = 49'(entry[g]) * 49'(weight[g]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PROD]) begin
         prod_ff   <= prod_in;
         unity6_ff <= unity;
      end
   end

   // sum, round to nearest, saturate, or give unity for a side with no table
   logic [49:0]        sum;
   logic [17:0]        res;
   logic [ENTRY_W-1:0] out_in, out_ff;

   assign sum = 50'(prod_ff[0]) + 50'(prod_ff[1]) + 50'(prod_ff[2]) + 50'(prod_ff[3]) + ROUND;
   assign res = sum[49:32];

   always_comb begin
      if (unity6_ff) begin
         out_in = UNITY;
      end else if (|res[17:16]) begin
         out_in = '1;
      end else begin
         out_in = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign loss_factor = out_ff;

endmodule

[dv/tb_top.sv]
module tb_top;
   import fbti_pkg::*;

   localparam int SIDE = SIDE_DEFAULT;

   // csr register indexes
   localparam logic REG_POS_SCALE = 1'b0;
   localparam logic REG_ANG_SCALE = 1'b1;

   // cycles to let a trailing table write leave the pipe
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 118;
   localparam int PHASES = 8;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // expected loss factors, own copy of both tables and both bin scales
   class loss_scoreboard_type;
      logic [15:0] table_q [2][SIDE][SIDE];
      logic [23:0] pos_scale;
      logic [23:0] ang_scale;
      logic [15:0] expected_q [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned writes;
      int unsigned lookups;

      function new();
         for (int s = 0; s < 2; s++)
            for (int r = 0; r < SIDE; r++)
               for (int c = 0; c < SIDE; c++)
                  table_q[s][r][c] = UNITY;
         pos_scale = POS_SCALE_RESET;
         ang_scale = ANG_SCALE_RESET;
      endfunction

      function void set_scale(logic idx, logic [23:0] value);
         if (idx == REG_POS_SCALE) pos_scale = value;
         else ang_scale = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // magnitude in Q.16 times Q8.16 scale, minus half a bin, clamped to the table
      function logic [63:0] bin_coord(logic [63:0] mag, logic [23:0] scale);
         logic [63:0] c;
         logic [63:0] top;
         top = 64'(SIDE - 1) << 16;
         c = (mag * {40'd0, scale}) >> 16;
         if (c <= 64'(HALF_Q16)) return 64'd0;
         c = c - 64'(HALF_Q16);
         if (c > top) c = top;
         return c;
      endfunction

      // edge neighbors clamp to the last bin
      function logic [63:0] entry(int s, int unsigned row, int unsigned col);
         if (row > SIDE - 1) row = SIDE - 1;
         if (col > SIDE - 1) col = SIDE - 1;
         return 64'(table_q[s][row][col]);
      endfunction

      function void note_request(fbti_req_type r);
         logic [15:0] frac;
         logic [63:0] pmag, amag, cp, ca, wp0, wp1, wa0, wa1, sum, res;
         int unsigned ip, ia;
         int s;
         if (r.op == OP_WRITE) begin
            writes++;
            if (r.side <= 2'd1 && r.entry_row < SIDE && r.entry_column < SIDE)
               table_q[r.side][r.entry_row][r.entry_column] = r.entry_value;
            return;
         end
         lookups++;
         if (r.side > 2'd1) begin
            expected_q.push_back(UNITY);
            return;
         end
         s = int'(r.side);
         // fold to the nearest strip center, exact half stays positive
         frac = r.strip_position[15:0];
         pmag = (frac <= 16'h8000) ? 64'(frac) : 64'(ONE_Q16) - 64'(frac);
         amag = r.impact_angle[23] ? 64'h1000000 - 64'(r.impact_angle[23:0])
                                   : 64'(r.impact_angle[23:0]);
         cp = bin_coord(pmag, pos_scale);
         ca = bin_coord(amag, ang_scale);
         ip = int'(cp[31:16]);
         ia = int'(ca[31:16]);
         wp1 = 64'(cp[15:0]);
         wp0 = 64'(ONE_Q16) - wp1;
         wa1 = 64'(ca[15:0]);
         wa0 = 64'(ONE_Q16) - wa1;
         sum = entry(s, ip, ia) * wp0 * wa0
             + entry(s, ip + 1, ia) * wp1 * wa0
             + entry(s, ip, ia + 1) * wp0 * wa1
             + entry(s, ip + 1, ia + 1) * wp1 * wa1;
         res = (sum + 64'h8000_0000) >> 32;
         if (res > 64'hFFFF) res = 64'hFFFF;
         expected_q.push_back(res[15:0]);
      endfunction

      function void check_response(logic [15:0] got);
         logic [15:0] want;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("response %h with no request pending", got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got !== want) begin
            if (mismatches < 10)
               $display("loss_factor wrong: expected %h got %h", want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: strip_position, impact_angle, entry_row, entry_column, entry_value
   logic [79:0] req_tdata = '0;
   // tuser: op, side
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata: loss_factor
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [23:0] csr_wdata = '0;

   loss_scoreboard_type sb = new();

   // idle odds in percent, set per phase by the stimulus process
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // long receiver hold-offs: requested by stimulus, served by the receiver
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int scale_settings = 1;

   folded_bilinear_table_interp u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check what got accepted at this edge, then pick next tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         // long stall so the pipe fills and backs up into req_tready
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic fbti_req_type make_query(logic [1:0] side, logic [31:0] pos,
                                               logic [23:0] ang);
      fbti_req_type r;
      r = '0;
      r.op = OP_QUERY;
      r.side = side;
      r.strip_position = pos;
      r.impact_angle = ang;
      return r;
   endfunction

   function automatic fbti_req_type make_write(logic [1:0] side, logic [3:0] row,
                                               logic [3:0] col, logic [15:0] value);
      fbti_req_type r;
      r = '0;
      r.op = OP_WRITE;
      r.side = side;
      r.entry_row = row;
      r.entry_column = col;
      r.entry_value = value;
      return r;
   endfunction

   // mostly in-table traffic with random content, some off-table sides and bad indexes
   function automatic fbti_req_type random_request();
      fbti_req_type r;
      logic [23:0] mag;
      r.op = ($urandom_range(0, 99) < 30) ? OP_WRITE : OP_QUERY;
      r.side = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 1))
                                           : 2'($urandom_range(2, 3));
      r.strip_position = $urandom();
      r.impact_angle = 24'($urandom());
      r.entry_row = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, SIDE - 1))
                                                : 4'($urandom());
      r.entry_column = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, SIDE - 1))
                                                   : 4'($urandom());
      case ($urandom_range(0, 9))
         0: r.entry_value = 16'h0000;
         1: r.entry_value = 16'hFFFF;
         2, 3: r.entry_value = UNITY + 16'($urandom_range(0, 8191)) - 16'd4096;
         default: r.entry_value = 16'($urandom());
      endcase
      // half the angles drawn at most 12.0 in magnitude, mostly inside the table at unit scale
      if ($urandom_range(0, 1) == 1) begin
         mag = 24'($urandom_range(0, 12 * 65536));
         r.impact_angle = ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
      if ($urandom_range(0, 19) == 0) r.impact_angle = 24'h800000;
      if ($urandom_range(0, 9) == 0)
         r.strip_position[15:0] = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h0000;
      return r;
   endfunction

   // offer one request with random lead-in gaps, return at the accepting edge
   task automatic send_request(input fbti_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.entry_value, r.entry_column, r.entry_row,
                    r.impact_angle, r.strip_position};
      req_tuser <= {r.side, r.op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   // stop offering, wait out every pending response and any trailing table write
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic idx, input logic [23:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_scale(idx, value);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 77; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 77; end
         default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
   endtask

   // main stimulus
   initial begin
      fbti_req_type directed [$];
      logic [23:0] pos_scale_set;
      logic [23:0] ang_scale_set;
      idle_mode_type mode;
      int failures;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset scales; table clearing after reset stalls the first one
      directed.push_back(make_query(2'd0, 32'h0000_0000, 24'h000000));
      directed.push_back(make_query(2'd2, 32'h1234_5678, 24'h123456));
      directed.push_back(make_query(2'd3, 32'hFFFF_FFFF, 24'hFFFFFF));
      directed.push_back(make_write(2'd0, 4'd0, 4'd0, 16'hFFFF));
      directed.push_back(make_write(2'd0, 4'd9, 4'd9, 16'h0000));
      directed.push_back(make_write(2'd1, 4'd0, 4'd9, 16'h0000));
      directed.push_back(make_write(2'd1, 4'd9, 4'd0, 16'hFFFF));
      directed.push_back(make_write(2'd0, 4'd4, 4'd0, 16'h2000));
      // writes that must be dropped: row or column off the table, side with no table
      directed.push_back(make_write(2'd0, 4'd10, 4'd0, 16'h0000));
      directed.push_back(make_write(2'd0, 4'd0, 4'd15, 16'h0000));
      directed.push_back(make_write(2'd2, 4'd0, 4'd0, 16'h0000));
      directed.push_back(make_write(2'd3, 4'd15, 4'd15, 16'h0000));
      directed.push_back(make_query(2'd0, 32'h0000_0000, 24'h000000));
      // exact half keeps the positive fraction, max and min angle clamp to the last bin
      directed.push_back(make_query(2'd0, 32'h0000_8000, 24'h7FFFFF));
      directed.push_back(make_query(2'd0, 32'h7FFF_FFFF, 24'h800000));
      directed.push_back(make_query(2'd1, 32'h8000_0000, 24'hFFFFFF));
      directed.push_back(make_query(2'd1, 32'h0001_8001, 24'h0A0000));
      directed.push_back(make_query(2'd1, 32'h0000_FFFF, 24'h048000));
      directed.push_back(make_query(2'd0, 32'h0000_4000, 24'h008000));
      directed.push_back(make_query(2'd0, 32'h0000_7FFF, 24'hFD0000));
      directed.push_back(make_query(2'd0, 32'hFFFF_6000, 24'h030000));
      directed.push_back(make_query(2'd3, 32'h0000_0000, 24'h000000));
      foreach (directed[i]) send_request(directed[i]);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin pos_scale_set = 24'h000000; ang_scale_set = 24'h000000;
                     mode = IDLE_SENDER; end
            1: begin pos_scale_set = 24'hFFFFFF; ang_scale_set = 24'hFFFFFF;
                     mode = IDLE_RECEIVER; end
            2: begin pos_scale_set = POS_SCALE_RESET; ang_scale_set = ANG_SCALE_RESET;
                     mode = IDLE_NONE; end
            3: begin pos_scale_set = 24'($urandom_range(16 * 65536, 24 * 65536));
                     ang_scale_set = 24'($urandom_range(32768, 3 * 65536));
                     mode = IDLE_BOTH; end
            4: begin pos_scale_set = 24'($urandom()); ang_scale_set = 24'($urandom());
                     mode = IDLE_SENDER; end
            5: begin pos_scale_set = 24'(20 * 65536); ang_scale_set = 24'h000001;
                     mode = IDLE_RECEIVER; end
            6: begin pos_scale_set = 24'($urandom_range(8 * 65536, 40 * 65536));
                     ang_scale_set = 24'($urandom_range(65536, 8 * 65536));
                     mode = IDLE_NONE; end
            default: begin pos_scale_set = 24'hFFFFFF; ang_scale_set = 24'h000000;
                     mode = IDLE_BOTH; end
         endcase
         // pipe is empty here, safe to retune the bins
         write_scale(REG_POS_SCALE, pos_scale_set);
         write_scale(REG_ANG_SCALE, ang_scale_set);
         scale_settings++;
         set_idling(mode);
         // back-pressure burst while the sender keeps offering
         if (ph == 2) hold_requests = hold_requests + 1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // sender pauses mid-phase until the pipe has drained
            if (ph == 3 && k == ITEMS_PER_PHASE / 2) drain();
            send_request(random_request());
         end
         drain();
      end

      // bounded final wait for stragglers
      req_tvalid <= 1'b0;
      for (int w = 0; w < 2000 && sb.pending() != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      failures = int'(sb.mismatches) + sb.pending();
      $display("covered %0d requests: %0d table writes, %0d lookups, %0d responses checked",
               sb.writes + sb.lookups, sb.writes, sb.lookups, sb.checked);
      $display("over %0d bin scale settings, %0d failures, %0d responses left over",
               scale_settings, failures, sb.pending());
      if (failures == 0) begin
         $display("folded_bilinear_table_interp: match");
      end else begin
         $display("folded_bilinear_table_interp: mismatch");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("folded_bilinear_table_interp: mismatch");
      $finish;
   end

endmodule
